FILE: design/kc3_pkg.sv
// Shared item type, constants and helper function of the 3x3 kernel convolution.
// Used by every module of the block but kc3_ram; depends on nothing else.
`timescale 1ns / 1ps
package kc3_pkg;

  // Image geometry.
  localparam int MAX_WIDTH   = 1024;
  localparam int HEIGHT_CAP  = 4096;
  localparam int MIN_SIZE    = 3;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(HEIGHT_CAP);
  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 13;

  // Pixel and kernel layout.
  localparam int CHAN        = 4;
  localparam int CHAN_W      = 8;
  localparam int PIX_W       = CHAN * CHAN_W;
  localparam int KERNEL_SIZE = 3;
  localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
  localparam int COEFF_BITS  = 7;
  localparam int KERNEL_W    = 63;
  localparam int DIV_W       = 8;

  // Arithmetic widths: an unsigned byte as a signed operand times a coefficient,
  // then a sum over nine taps.
  localparam int PROD_W      = CHAN_W + 1 + COEFF_BITS;
  localparam int SUM_W       = PROD_W + 4;
  localparam int MAG_W       = SUM_W - 1;
  localparam int DIV_STEPS   = MAG_W;
  localparam int STEP_W      = $clog2(DIV_STEPS + 1);

  // Queue between the front and the back end.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Configuration register indexes.
  localparam int CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_DIVISOR = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COEFFS = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [WIDTH_W-1:0]  RESET_WIDTH   = 11'd64;
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT  = 13'd64;
  localparam logic [DIV_W-1:0]    RESET_DIVISOR = 8'd1;
  localparam logic [KERNEL_W-1:0] RESET_KERNEL  = 63'd71499009379811200;

  // One classified item handed from the front to the back end.
  typedef struct packed {
    logic [COL_W-1:0]                col;
    logic [ROW_W-1:0]                row;
    logic [PIX_W-1:0]                pixel;
    logic                            filt;
    logic                            border;
    logic [CHAN-1:0][SUM_W-1:0]      sums;
  } job_t;

  // Signed coefficient at packed index idx.
  function automatic logic signed [COEFF_BITS-1:0] coeff_at(
      input logic [KERNEL_W-1:0] kernel, input int idx);
    coeff_at = kernel[COEFF_BITS*idx +: COEFF_BITS];
  endfunction

endpackage

FILE: design/kc3_ram.sv
// Generic single-write, single-read RAM with registered, read-first output.
// Stand-alone; no package needed.
`timescale 1ns / 1ps
module kc3_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read; a read of the written address sees old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/kc3_front.sv
// Front end: raster counters, line buffers, 3x3 window and kernel sums.
// Depends on kc3_pkg and kc3_ram.
`timescale 1ns / 1ps
module kc3_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [kc3_pkg::CHAN_W-1:0]   in_red,
  input  logic [kc3_pkg::CHAN_W-1:0]   in_green,
  input  logic [kc3_pkg::CHAN_W-1:0]   in_blue,
  input  logic [kc3_pkg::CHAN_W-1:0]   in_alpha,
  input  logic [kc3_pkg::WIDTH_W-1:0]  image_width,
  input  logic [kc3_pkg::HEIGHT_W-1:0] image_height,
  input  logic [kc3_pkg::KERNEL_W-1:0] kernel_coeffs,
  output kc3_pkg::job_t                job,
  output logic                         job_push,
  input  logic                         job_full
);

  logic [kc3_pkg::COL_W-1:0]    col_count, col_next;
  logic [kc3_pkg::ROW_W-1:0]    row_count, row_next;
  logic [kc3_pkg::WIDTH_W-1:0]  w_eff;
  logic [kc3_pkg::HEIGHT_W-1:0] h_eff;
  logic [kc3_pkg::COL_W-1:0]    c_cur;
  logic [kc3_pkg::ROW_W-1:0]    r_cur;
  logic [kc3_pkg::HEIGHT_W-1:0] r_inc, r_adv;
  logic [kc3_pkg::WIDTH_W-1:0]  c_adv;
  logic                         wrap_c;
  logic                         cur_filt, cur_border;
  logic                         advance, accept;
  logic [kc3_pkg::PIX_W-1:0]    in_px;
  logic [kc3_pkg::PIX_W-1:0]    rd0, rd1;

  logic                         s1_valid, s2_valid, s3_valid;
  logic [kc3_pkg::COL_W-1:0]    s1_col, s2_col, s3_col;
  logic [kc3_pkg::ROW_W-1:0]    s1_row, s2_row, s3_row;
  logic [kc3_pkg::PIX_W-1:0]    s1_px, s2_px, s3_px;
  logic                         s1_filt, s2_filt, s3_filt;
  logic                         s1_border, s2_border, s3_border;

  logic [kc3_pkg::PIX_W-1:0]        win [kc3_pkg::TAPS];
  logic signed [kc3_pkg::PROD_W-1:0] prod [kc3_pkg::CHAN][kc3_pkg::TAPS];
  logic signed [kc3_pkg::SUM_W-1:0]  sum_c [kc3_pkg::CHAN];

  assign in_px = {in_alpha, in_blue, in_green, in_red};

  // Size limits used for counting.
  always_comb begin
    if (image_width < kc3_pkg::WIDTH_W'(kc3_pkg::MIN_SIZE)) begin
      w_eff = kc3_pkg::WIDTH_W'(kc3_pkg::MIN_SIZE);
    end else if (image_width > kc3_pkg::WIDTH_W'(kc3_pkg::MAX_WIDTH)) begin
      w_eff = kc3_pkg::WIDTH_W'(kc3_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height < kc3_pkg::HEIGHT_W'(kc3_pkg::MIN_SIZE)) begin
      h_eff = kc3_pkg::HEIGHT_W'(kc3_pkg::MIN_SIZE);
    end else if (image_height > kc3_pkg::HEIGHT_W'(kc3_pkg::HEIGHT_CAP)) begin
      h_eff = kc3_pkg::HEIGHT_W'(kc3_pkg::HEIGHT_CAP);
    end else begin
      h_eff = image_height;
    end
  end

  // Position of the incoming item and the counters after it.
  always_comb begin
    wrap_c = {1'b0, col_count} >= w_eff;
    c_cur  = wrap_c ? '0 : col_count;
    r_inc  = wrap_c ? {1'b0, row_count} + 1'b1 : {1'b0, row_count};
    r_cur  = (r_inc >= h_eff) ? '0 : r_inc[kc3_pkg::ROW_W-1:0];
    c_adv  = {1'b0, c_cur} + 1'b1;
    r_adv  = {1'b0, r_cur} + 1'b1;
    if (c_adv >= w_eff) begin
      col_next = '0;
      row_next = (r_adv >= h_eff) ? '0 : r_adv[kc3_pkg::ROW_W-1:0];
    end else begin
      col_next = c_adv[kc3_pkg::COL_W-1:0];
      row_next = r_cur;
    end
    cur_filt   = (c_cur >= kc3_pkg::COL_W'(2)) && (r_cur >= kc3_pkg::ROW_W'(2));
    cur_border = (c_cur == '0) || ({1'b0, c_cur} == w_eff - 1'b1) ||
                 (r_cur == '0) || ({1'b0, r_cur} == h_eff - 1'b1);
  end

  // The whole pipe moves together unless the last stage cannot hand over.
  assign advance  = !(s3_valid && (s3_filt || s3_border) && job_full);
  assign full     = !advance;
  assign accept   = push && advance;
  assign job_push = s3_valid && (s3_filt || s3_border) && !job_full;

  // Line buffers: one bank per row parity; the item overwrites its own bank.
  kc3_ram #(.WIDTH(kc3_pkg::PIX_W), .DEPTH(kc3_pkg::MAX_WIDTH)) u_line0 (
    .clk   (clk),
    .we    (accept && !r_cur[0]),
    .waddr (c_cur),
    .wdata (in_px),
    .re    (accept),
    .raddr (c_cur),
    .rdata (rd0)
  );

  kc3_ram #(.WIDTH(kc3_pkg::PIX_W), .DEPTH(kc3_pkg::MAX_WIDTH)) u_line1 (
    .clk   (clk),
    .we    (accept && r_cur[0]),
    .waddr (c_cur),
    .wdata (in_px),
    .re    (accept),
    .raddr (c_cur),
    .rdata (rd1)
  );

  // Counters and pipeline control.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
    end else begin
      if (accept) begin
        col_count <= col_next;
        row_count <= row_next;
      end
      if (advance) begin
        s1_valid <= accept;
        s2_valid <= s1_valid;
        s3_valid <= s2_valid;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_col    <= c_cur;
      s1_row    <= r_cur;
      s1_px     <= in_px;
      s1_filt   <= cur_filt;
      s1_border <= cur_border;
      s2_col    <= s1_col;
      s2_row    <= s1_row;
      s2_px     <= s1_px;
      s2_filt   <= s1_filt;
      s2_border <= s1_border;
      s3_col    <= s2_col;
      s3_row    <= s2_row;
      s3_px     <= s2_px;
      s3_filt   <= s2_filt;
      s3_border <= s2_border;
    end
  end

  // Window shift: the line buffer data of the stage-one item enters the right column.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < kc3_pkg::TAPS; t++) begin
        win[t] <= '0;
      end
    end else if (advance && s1_valid) begin
      for (int y = 0; y < kc3_pkg::KERNEL_SIZE; y++) begin
        win[y*3 + 0] <= win[y*3 + 1];
        win[y*3 + 1] <= win[y*3 + 2];
      end
      win[2] <= s1_row[0] ? rd1 : rd0;
      win[5] <= s1_row[0] ? rd0 : rd1;
      win[8] <= s1_px;
    end
  end

  // Products: the coefficient with index x*3+y weights window tap y*3+x.
  always_ff @(posedge clk) begin
    if (advance) begin
      for (int ch = 0; ch < kc3_pkg::CHAN; ch++) begin
        for (int y = 0; y < kc3_pkg::KERNEL_SIZE; y++) begin
          for (int x = 0; x < kc3_pkg::KERNEL_SIZE; x++) begin
            prod[ch][y*3 + x] <=
              $signed({1'b0, win[y*3 + x][kc3_pkg::CHAN_W*ch +: kc3_pkg::CHAN_W]}) *
              kc3_pkg::coeff_at(kernel_coeffs, x*3 + y);
          end
        end
      end
    end
  end

  // Channel sums over the nine products.
  always_comb begin
    for (int ch = 0; ch < kc3_pkg::CHAN; ch++) begin
      sum_c[ch] = '0;
      for (int t = 0; t < kc3_pkg::TAPS; t++) begin
        sum_c[ch] = sum_c[ch] + kc3_pkg::SUM_W'(prod[ch][t]);
      end
    end
  end

  // Item handed to the queue.
  always_comb begin
    job.col    = s3_col;
    job.row    = s3_row;
    job.pixel  = s3_px;
    job.filt   = s3_filt;
    job.border = s3_border;
    for (int ch = 0; ch < kc3_pkg::CHAN; ch++) begin
      job.sums[ch] = sum_c[ch];
    end
  end

endmodule

FILE: design/kc3_queue.sv
// Short first-in first-out queue of classified items between front and back end.
// Depends on kc3_pkg.
`timescale 1ns / 1ps
module kc3_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  kc3_pkg::job_t data_in,
  output logic          full,
  input  logic          pop,
  output kc3_pkg::job_t data_out,
  output logic          empty
);

  kc3_pkg::job_t               slots [kc3_pkg::QUEUE_DEPTH];
  logic [kc3_pkg::QPTR_W-1:0]  head, tail;
  logic [kc3_pkg::QPTR_W:0]    count;

  assign full     = count == (kc3_pkg::QPTR_W+1)'(kc3_pkg::QUEUE_DEPTH);
  assign empty    = count == '0;
  assign data_out = slots[head];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= tail + 1'b1;
      end
      if (pop) begin
        head <= head + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[tail] <= data_in;
    end
  end

endmodule

FILE: design/kc3_back.sv
// Back end: bit-serial signed division of the channel sums and result output register.
// Depends on kc3_pkg.
`timescale 1ns / 1ps
module kc3_back (
  input  logic                        clk,
  input  logic                        rst,
  input  kc3_pkg::job_t               job,
  input  logic                        job_empty,
  output logic                        job_pop,
  input  logic [kc3_pkg::DIV_W-1:0]   scale_divisor,
  output logic                        empty,
  input  logic                        pop,
  output logic [kc3_pkg::COL_W-1:0]   out_col,
  output logic [kc3_pkg::ROW_W-1:0]   out_row,
  output logic [kc3_pkg::CHAN_W-1:0]  out_red,
  output logic [kc3_pkg::CHAN_W-1:0]  out_green,
  output logic [kc3_pkg::CHAN_W-1:0]  out_blue,
  output logic [kc3_pkg::CHAN_W-1:0]  out_alpha,
  output logic                        run_last
);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT_F, ST_EMIT_B} state_t;

  state_t                      state;
  logic                        out_valid, out_free, emit;
  logic [kc3_pkg::COL_W-1:0]   cur_col;
  logic [kc3_pkg::ROW_W-1:0]   cur_row;
  logic [kc3_pkg::PIX_W-1:0]   cur_px;
  logic                        cur_border;
  logic [kc3_pkg::DIV_W-1:0]   div_r;
  logic [kc3_pkg::STEP_W-1:0]  step;
  logic [kc3_pkg::MAG_W-1:0]   mag [kc3_pkg::CHAN];
  logic [kc3_pkg::MAG_W-1:0]   quo [kc3_pkg::CHAN];
  logic [kc3_pkg::DIV_W-1:0]   rem [kc3_pkg::CHAN];
  logic                        neg [kc3_pkg::CHAN];
  logic [kc3_pkg::DIV_W:0]     trial [kc3_pkg::CHAN];
  logic                        fits [kc3_pkg::CHAN];
  logic [kc3_pkg::CHAN_W-1:0]  qbyte [kc3_pkg::CHAN];
  logic signed [kc3_pkg::SUM_W-1:0] jsum [kc3_pkg::CHAN];

  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;
  assign job_pop  = (state == ST_IDLE) && !job_empty;
  assign emit     = out_free && ((state == ST_EMIT_F) || (state == ST_EMIT_B));

  // One restoring division step per channel, and the wrapped signed quotient byte.
  always_comb begin
    for (int ch = 0; ch < kc3_pkg::CHAN; ch++) begin
      trial[ch] = {rem[ch], mag[ch][kc3_pkg::MAG_W-1]};
      fits[ch]  = trial[ch] >= {1'b0, div_r};
      qbyte[ch] = neg[ch] ? kc3_pkg::CHAN_W'(~quo[ch][kc3_pkg::CHAN_W-1:0] + 1'b1)
                          : quo[ch][kc3_pkg::CHAN_W-1:0];
      jsum[ch]  = job.sums[ch];
    end
  end

  // Sequencer, divider registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!job_empty) begin
            cur_col    <= job.col;
            cur_row    <= job.row;
            cur_px     <= job.pixel;
            cur_border <= job.border;
            div_r      <= (scale_divisor == '0) ? kc3_pkg::DIV_W'(1) : scale_divisor;
            step       <= '0;
            for (int ch = 0; ch < kc3_pkg::CHAN; ch++) begin
              neg[ch] <= jsum[ch][kc3_pkg::SUM_W-1];
              mag[ch] <= jsum[ch][kc3_pkg::SUM_W-1] ?
                         kc3_pkg::MAG_W'(-jsum[ch]) : kc3_pkg::MAG_W'(jsum[ch]);
              rem[ch] <= '0;
              quo[ch] <= '0;
            end
            state <= job.filt ? ST_DIV : ST_EMIT_B;
          end
        end
        ST_DIV: begin
          for (int ch = 0; ch < kc3_pkg::CHAN; ch++) begin
            rem[ch] <= fits[ch] ? kc3_pkg::DIV_W'(trial[ch] - {1'b0, div_r})
                                : kc3_pkg::DIV_W'(trial[ch]);
            quo[ch] <= {quo[ch][kc3_pkg::MAG_W-2:0], fits[ch]};
            mag[ch] <= {mag[ch][kc3_pkg::MAG_W-2:0], 1'b0};
          end
          step <= step + 1'b1;
          if (step == kc3_pkg::STEP_W'(kc3_pkg::DIV_STEPS - 1)) begin
            state <= ST_EMIT_F;
          end
        end
        ST_EMIT_F: begin
          if (out_free) begin
            out_col   <= cur_col - 1'b1;
            out_row   <= cur_row - 1'b1;
            out_red   <= qbyte[0];
            out_green <= qbyte[1];
            out_blue  <= qbyte[2];
            out_alpha <= qbyte[3];
            run_last  <= !cur_border;
            state     <= cur_border ? ST_EMIT_B : ST_IDLE;
          end
        end
        ST_EMIT_B: begin
          if (out_free) begin
            out_col   <= cur_col;
            out_row   <= cur_row;
            out_red   <= cur_px[0*kc3_pkg::CHAN_W +: kc3_pkg::CHAN_W];
            out_green <= cur_px[1*kc3_pkg::CHAN_W +: kc3_pkg::CHAN_W];
            out_blue  <= cur_px[2*kc3_pkg::CHAN_W +: kc3_pkg::CHAN_W];
            out_alpha <= cur_px[3*kc3_pkg::CHAN_W +: kc3_pkg::CHAN_W];
            run_last  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: design/kernel_convolution_3x3.sv
// Top level of the 3x3 integer-kernel convolution: configuration registers,
// front end, item queue and back end. Depends on kc3_pkg, kc3_front, kc3_queue, kc3_back.
//
// Usage: RGBA pixels are pushed in raster order (push while full is low). Each
// pixel yields up to two results, read like a queue (pop while empty is low):
// first the filtered pixel centred one row and one column back, once the 3x3
// window is complete, then the pixel itself unchanged if it lies on the image
// border. run_last marks the last result of a pixel; some pixels yield none.
// Configuration registers are written through cfg_write, cfg_index and
// cfg_data while the block is idle, and take effect at once.
// Each item passes through three front stages and the queue, then the back end.
// Throughput: the front takes one pixel a cycle while its four-entry queue has
// room; the back end divides a filtered item (19 quotient bits, one bit a cycle,
// all four channels at once), then emits it and, on the border, the pixel; it
// takes the next item only when back in idle. The divider sets the sustained rate.
// Reset (synchronous, rst high) empties the pipe and queue, zeroes the counters
// and window and reloads register defaults; line buffers are not cleared.
// When pop is held low the result stays on the ports, the back end waits, and
// full rises once the queue is full and the last front stage holds an item for it.
`timescale 1ns / 1ps
module kernel_convolution_3x3 (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [kc3_pkg::CHAN_W-1:0]    in_red,
  input  logic [kc3_pkg::CHAN_W-1:0]    in_green,
  input  logic [kc3_pkg::CHAN_W-1:0]    in_blue,
  input  logic [kc3_pkg::CHAN_W-1:0]    in_alpha,
  output logic                          empty,
  input  logic                          pop,
  output logic [kc3_pkg::COL_W-1:0]     out_col,
  output logic [kc3_pkg::ROW_W-1:0]     out_row,
  output logic [kc3_pkg::CHAN_W-1:0]    out_red,
  output logic [kc3_pkg::CHAN_W-1:0]    out_green,
  output logic [kc3_pkg::CHAN_W-1:0]    out_blue,
  output logic [kc3_pkg::CHAN_W-1:0]    out_alpha,
  output logic                          run_last,
  input  logic                          cfg_write,
  input  logic [kc3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kc3_pkg::KERNEL_W-1:0]  cfg_data
);

  logic [kc3_pkg::WIDTH_W-1:0]  image_width;
  logic [kc3_pkg::HEIGHT_W-1:0] image_height;
  logic [kc3_pkg::DIV_W-1:0]    scale_divisor;
  logic [kc3_pkg::KERNEL_W-1:0] kernel_coeffs;

  kc3_pkg::job_t job_in, job_out;
  logic          job_push, job_full, job_pop, job_empty;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width   <= kc3_pkg::RESET_WIDTH;
      image_height  <= kc3_pkg::RESET_HEIGHT;
      scale_divisor <= kc3_pkg::RESET_DIVISOR;
      kernel_coeffs <= kc3_pkg::RESET_KERNEL;
    end else if (cfg_write) begin
      case (cfg_index)
        kc3_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data[kc3_pkg::WIDTH_W-1:0];
        kc3_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data[kc3_pkg::HEIGHT_W-1:0];
        kc3_pkg::REG_SCALE_DIVISOR: scale_divisor <= cfg_data[kc3_pkg::DIV_W-1:0];
        kc3_pkg::REG_KERNEL_COEFFS: kernel_coeffs <= cfg_data;
        default: ;
      endcase
    end
  end

  kc3_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .in_alpha      (in_alpha),
    .image_width   (image_width),
    .image_height  (image_height),
    .kernel_coeffs (kernel_coeffs),
    .job           (job_in),
    .job_push      (job_push),
    .job_full      (job_full)
  );

  kc3_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .data_in  (job_in),
    .full     (job_full),
    .pop      (job_pop),
    .data_out (job_out),
    .empty    (job_empty)
  );

  kc3_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job           (job_out),
    .job_empty     (job_empty),
    .job_pop       (job_pop),
    .scale_divisor (scale_divisor),
    .empty         (empty),
    .pop           (pop),
    .out_col       (out_col),
    .out_row       (out_row),
    .out_red       (out_red),
    .out_green     (out_green),
    .out_blue      (out_blue),
    .out_alpha     (out_alpha),
    .run_last      (run_last)
  );

  // The front end never pushes into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    job_push |-> !job_full)
    else $error("item pushed into a full queue");

  // The back end never takes an item from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    job_pop |-> !job_empty)
    else $error("item taken from an empty queue");

  // A waiting result is not dropped before it is taken.
  a_result_kept: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty)
    else $error("waiting result lost");

endmodule
